@@ sv/ads_pkg.sv @@
// ads_pkg: shared constants, types and the order-key function for argsort_doubles.
// No dependencies.
package ads_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned ValW     = 64;

  typedef logic [ValW-1:0] key_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [CntW-1:0] cnt_t;

  // Contents of one sorting cell.
  typedef struct packed {
    logic vld;
    key_t key;
    pos_t pos;
  } slot_t;

  // Map double bits to an unsigned key ordered like the values; both zeros match.
  function automatic key_t order_key(input logic [ValW-1:0] bits);
    logic [ValW-1:0] b;
    b = bits;
    if (b[ValW-2:0] == '0) begin
      b = '0;
    end
    if (b[ValW-1]) begin
      order_key = ~b;
    end else begin
      order_key = {1'b1, b[ValW-2:0]};
    end
  endfunction

endpackage

@@ sv/ads_cell.sv @@
// ads_cell: one slot of the insertion-sort chain.
// Depends on ads_pkg.
module ads_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ins_i,       // insert the new word this cycle
  input  logic          shift_i,     // pop: take the right neighbor's slot
  input  ads_pkg::key_t new_key_i,
  input  ads_pkg::pos_t new_pos_i,
  input  ads_pkg::slot_t left_i,     // neighbor toward the head
  input  ads_pkg::slot_t right_i,    // neighbor toward the tail
  input  logic          left_gt_i,   // left neighbor moves down this cycle
  output logic          gt_o,        // this slot holds a key above the new one
  output ads_pkg::slot_t slot_o
);
  import ads_pkg::*;

  slot_t slot_q, slot_d;

  // Strict compare keeps equal keys in arrival order.
  assign gt_o   = slot_q.vld && (slot_q.key > new_key_i);
  assign slot_o = slot_q;

  // Insert: shift down behind the new word, or take it in the gap.
  // An empty slot is the gap only when its left neighbor is filled.
  always_comb begin
    slot_d = slot_q;
    if (shift_i) begin
      slot_d = right_i;
    end else if (ins_i) begin
      if (left_gt_i) begin
        slot_d = left_i;
      end else if (gt_o || (!slot_q.vld && left_i.vld)) begin
        slot_d = '{vld: 1'b1, key: new_key_i, pos: new_pos_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

@@ sv/argsort_doubles.sv @@
// argsort_doubles: stable argsort of IEEE doubles via a chain of insertion cells.
// Depends on ads_pkg and ads_cell.
//
//  channel | signals                                     | direction
//  in      | in_valid_i, in_ready_o, value_i, last_i     | input words
//  out     | out_valid_o, out_ready_i, position_o,       | result words
//          |   last_res_o, overflow_o                    |
//
// Loading takes one word per cycle; each word is inserted into the cell chain
// in the cycle it is accepted. After the last word, the chain pops one position
// per cycle from its head. Input is held off while a set is emitted. Reset
// empties the chain and the counters. Output stalls freeze the chain.
module argsort_doubles (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [63:0]            value_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ads_pkg::PosW-1:0] position_o,
  output logic                   last_res_o,
  output logic                   overflow_o
);
  import ads_pkg::*;

  localparam int unsigned N = MaxItems;

  cnt_t  cnt_q, cnt_d;
  logic  ovf_q, ovf_d;
  logic  emit_q, emit_d;
  cnt_t  rem_q, rem_d;

  key_t  new_key;
  logic  acc, pop, store;
  slot_t slots [N+1];
  logic  gts   [N];

  assign new_key    = order_key(value_i);
  assign in_ready_o = !emit_q;
  assign acc        = in_valid_i && in_ready_o;
  assign store      = acc && (cnt_q < cnt_t'(N));
  assign out_valid_o = emit_q && slots[0].vld;
  assign pop        = out_valid_o && out_ready_i;

  assign slots[N] = '0;

  // Cell chain: head at index 0 holds the smallest key.
  for (genvar g = 0; g < N; g++) begin : g_cell
    slot_t left_s;
    logic  left_gt;
    if (g == 0) begin : g_head
      // head sees a filled neighbor that never moves down
      assign left_s  = '{vld: 1'b1, key: '0, pos: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_s  = slots[g-1];
      assign left_gt = gts[g-1];
    end
    ads_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (store),
      .shift_i   (pop),
      .new_key_i (new_key),
      .new_pos_i (cnt_q[PosW-1:0]),
      .left_i    (left_s),
      .right_i   (slots[g+1]),
      .left_gt_i (left_gt),
      .gt_o      (gts[g]),
      .slot_o    (slots[g])
    );
  end

  assign position_o = slots[0].pos;
  assign last_res_o = (rem_q == cnt_t'(1));
  assign overflow_o = ovf_q;

  // Set bookkeeping and emission control.
  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    emit_d = emit_q;
    rem_d  = rem_q;
    if (acc) begin
      if (store) begin
        cnt_d = cnt_q + cnt_t'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        emit_d = 1'b1;
        rem_d  = store ? cnt_q + cnt_t'(1) : cnt_q;
      end
    end
    if (pop) begin
      rem_d = rem_q - cnt_t'(1);
      if (rem_q == cnt_t'(1)) begin
        emit_d = 1'b0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      emit_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      emit_q <= emit_d;
      rem_q  <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_no_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> !in_ready_o) else $error("input taken during emission");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(N)) else $error("element count past capacity");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (rem_q <= cnt_q)) else $error("remaining count past stored");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && last_res_o) |=> (cnt_q == '0 && !emit_q)) else $error("set not closed");
`endif

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for argsort_doubles (stable index sort of doubles).
// Depends on ads_pkg and argsort_doubles; predicts sorted positions per set.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ads_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } in_word_t;

  typedef struct packed {
    pos_t position;
    logic last_res;
    logic overflow;
  } out_word_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [63:0] value_i;
  logic        last_i;
  logic        out_valid_o, out_ready_i;
  pos_t        position_o;
  logic        last_res_o, overflow_o;

  argsort_doubles uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .value_i(value_i), .last_i(last_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .position_o(position_o), .last_res_o(last_res_o), .overflow_o(overflow_o)
  );

  in_word_t  pending_words[$];
  out_word_t sorted_expect[$];
  logic [63:0] set_values[$];
  bit  set_overflow;
  int  errors, words_sent, results_seen, sets_closed;
  bit  stim_done, no_idle, hold_rx;
  int  idle_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Value ordering key: both zeros equal, negatives reversed
  function automatic logic [63:0] sort_key(logic [63:0] bits);
    logic [63:0] b;
    b = bits;
    if (b[62:0] == '0) b = '0;
    if (b[63]) return ~b;
    return {1'b1, b[62:0]};
  endfunction

  // Feed one word into the predictor; on last, emit the expected positions
  task automatic predict_word(in_word_t w);
    logic [63:0] keys[64];
    int ord[64];
    int n, i, j;
    out_word_t ew;
    if (set_values.size() < MaxItems) set_values = {set_values, w.value};
    else set_overflow = 1'b1;
    if (!w.last) return;
    n = set_values.size();
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && keys[j-1] > sort_key(set_values[i])) begin
        keys[j] = keys[j-1];
        ord[j] = ord[j-1];
        j--;
      end
      keys[j] = sort_key(set_values[i]);
      ord[j] = i;
    end
    for (i = 0; i < n; i++) begin
      ew = '{pos_t'(ord[i]), i == n - 1, set_overflow};
      sorted_expect = {sorted_expect, ew};
    end
    set_values.delete();
    set_overflow = 1'b0;
    sets_closed++;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: v = {$urandom_range(0, 1) == 1, 63'h0};
      2: v = {$urandom_range(0, 1) == 1, 11'h7ff, 52'h0};
      3: v = {$urandom_range(0, 1) == 1, 11'h3ff, 49'h0, 3'($urandom_range(0, 3))};
      4: v = {$urandom_range(0, 1) == 1, 11'h0, 20'h0, $urandom};
      default: v = {$urandom_range(0, 1) == 1, 11'($urandom_range(0, 2046)),
                    20'($urandom), $urandom};
    endcase
    return v;
  endfunction

  // Append one word to the stimulus queue
  task automatic queue_word(logic [63:0] v, logic l);
    in_word_t w;
    w = '{v, l};
    pending_words = {pending_words, w};
  endtask

  task automatic add_set(int n);
    for (int i = 0; i < n; i++)
      queue_word(rand_double(), i == n - 1);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      last_i     <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_word('{value_i, last_i});
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
          in_word_t w;
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= w.value;
          last_i     <= w.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected word pos=%0d last=%0b ovf=%0b",
                   $time, position_o, last_res_o, overflow_o);
        end else begin
          out_word_t e;
          e = sorted_expect.pop_front();
          if (e.position !== position_o) begin
            errors++;
            $display("%0t: position expected %0d got %0d", $time, e.position, position_o);
          end
          if (e.last_res !== last_res_o) begin
            errors++;
            $display("%0t: last_res expected %0b got %0b", $time, e.last_res, last_res_o);
          end
          if (e.overflow !== overflow_o) begin
            errors++;
            $display("%0t: overflow expected %0b got %0b", $time, e.overflow, overflow_o);
          end
        end
      end
      out_ready_i <= !hold_rx && (no_idle || $urandom_range(0, 99) >= 33);
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors = 0; words_sent = 0; results_seen = 0; sets_closed = 0;
    set_overflow = 1'b0; no_idle = 1'b0; hold_rx = 1'b0; idle_cycles = 0;
    rst_ni = 1'b0;
    // directed: single element, zeros, infinities, extremes, equal values
    queue_word(64'h3ff0000000000000, 1'b1);
    queue_word(64'h0000000000000000, 1'b0);
    queue_word(64'h8000000000000000, 1'b0);
    queue_word(64'h7ff0000000000000, 1'b0);
    queue_word(64'hfff0000000000000, 1'b0);
    queue_word(64'h0000000000000001, 1'b0);
    queue_word(64'h8000000000000001, 1'b0);
    queue_word(64'h7fefffffffffffff, 1'b0);
    queue_word(64'hffefffffffffffff, 1'b0);
    queue_word(64'h3ff0000000000000, 1'b0);
    queue_word(64'hbff0000000000000, 1'b0);
    queue_word(64'h0000000000000000, 1'b1);
    queue_word(64'hffffffffffffffff, 1'b0);
    queue_word(64'h5555555555555555, 1'b0);
    queue_word(64'haaaaaaaaaaaaaaaa, 1'b1);
    repeat (12) @(posedge clk_i);
    rst_ni = 1'b1;
    // full capacity plus overflow, the last word dropped but closing the set
    add_set(66);
    add_set(2);
    // long pressure: receiver held off while sender keeps offering words
    hold_rx = 1'b1;
    add_set(8);
    repeat (200) @(posedge clk_i);
    hold_rx = 1'b0;
    // random sets, mostly small
    for (int k = 0; k < 3; k++) add_set($urandom_range(1, 5));
    no_idle = 1'b1;
    for (int k = 0; k < 2; k++) add_set($urandom_range(3, 6));
    wait (pending_words.size() == 0);
    no_idle = 1'b0;
    for (int k = 0; k < 2; k++) add_set($urandom_range(1, 4));
    wait (pending_words.size() == 0 && !(in_valid_i === 1'b1));
    wait (sorted_expect.size() == 0);
    repeat (150) @(posedge clk_i);
    $display("covered %0d words in %0d sets, %0d positions checked",
             words_sent, sets_closed, results_seen);
    if (errors == 0 && sorted_expect.size() == 0 && set_values.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
